/* design/bglt_pkg.sv */
// ----------------------------------------------------------------------------
// bglt_pkg
// Shared types, codes and reset values for the beam gate lap timer.
// ----------------------------------------------------------------------------
package bglt_pkg;

  // command codes (s_tuser)
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOCK  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // finish causes
  localparam logic [2:0] CAUSE_NONE         = 3'd0;
  localparam logic [2:0] CAUSE_GOAL         = 3'd1;
  localparam logic [2:0] CAUSE_RACE_TIMEOUT = 3'd2;
  localparam logic [2:0] CAUSE_RESET        = 3'd3;
  localparam logic [2:0] CAUSE_LOCK_EXPIRED = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_LAP_GOAL        = 2'd0;
  localparam logic [1:0] REG_MIN_LAP_MS      = 2'd1;
  localparam logic [1:0] REG_LOCK_TIMEOUT_MS = 2'd2;
  localparam logic [1:0] REG_RACE_TIMEOUT_MS = 2'd3;

  // configuration reset values
  localparam logic [7:0]  LAP_GOAL_RST        = 8'd0;
  localparam logic [15:0] MIN_LAP_MS_RST      = 16'd500;
  localparam logic [31:0] LOCK_TIMEOUT_MS_RST = 32'd90000;
  localparam logic [31:0] RACE_TIMEOUT_MS_RST = 32'd600000;

  localparam logic [15:0] LAPS_MAX = 16'hFFFF;

  // port widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 128;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  typedef struct packed {
    logic [7:0]  lap_goal;
    logic [15:0] min_lap_ms;
    logic [31:0] lock_timeout_ms;
    logic [31:0] race_timeout_ms;
  } bglt_cfg_t;

  typedef struct packed {
    logic        locked;
    logic        running;
    logic        ready;
    logic        armed;
    logic        prev_beam;
    logic [31:0] lock_time;
    logic [31:0] start_time;
    logic [31:0] last_lap_time;
    logic [15:0] laps_done;
  } bglt_state_t;

  typedef struct packed {
    logic        cmd_ok;
    logic        lap_recorded;
    logic [31:0] lap_ms;
    logic [15:0] lap_count;
    logic [2:0]  finish_cause;
    logic [31:0] total_ms;
    logic        track_locked;
    logic        race_running;
    logic        start_ready;
    logic        lap_armed;
    logic [31:0] timer_ms;
  } bglt_result_t;

  // drop the race and the lock; the beam history is kept
  function automatic bglt_state_t clear_track(input bglt_state_t st);
    bglt_state_t r;
    r               = '0;
    r.prev_beam     = st.prev_beam;
    return r;
  endfunction

endpackage

/* design/bglt_step.sv */
// ----------------------------------------------------------------------------
// bglt_step
// Next-state and result logic for one word: beam edges, laps, lock, timeouts.
// ----------------------------------------------------------------------------
module bglt_step
  import bglt_pkg::*;
(
  input  bglt_cfg_t    cfg,
  input  bglt_state_t  st,
  input  logic [1:0]   cmd,
  input  logic         beam_broken,
  input  logic [31:0]  now_ms,
  output bglt_state_t  st_next,
  output bglt_result_t res
);

  logic [31:0] d_lap;
  logic [31:0] d_start;
  logic [31:0] d_lock;
  logic [31:0] d_start_eff;
  logic [15:0] laps_inc;
  logic        started;
  logic [15:0] final_count;

  assign d_lap    = now_ms - st.last_lap_time;
  assign d_start  = now_ms - st.start_time;
  assign d_lock   = now_ms - st.lock_time;
  assign laps_inc = (st.laps_done != LAPS_MAX) ? st.laps_done + 16'd1 : st.laps_done;

  always_comb begin
    st_next          = st;
    started          = 1'b0;
    final_count      = '0;
    res              = '0;
    res.cmd_ok       = 1'b1;

    unique case (cmd)
      CMD_TICK: begin
        if (beam_broken != st.prev_beam) begin
          if (st.locked) begin
            if (!st.running) begin
              if (!beam_broken) begin
                st_next.ready = 1'b1;
              end else if (st.ready) begin
                st_next.running       = 1'b1;
                st_next.ready         = 1'b0;
                st_next.armed         = 1'b0;
                st_next.start_time    = now_ms;
                st_next.last_lap_time = now_ms;
                started               = 1'b1;
              end
            end else if (!beam_broken) begin
              st_next.armed = 1'b1;
            end else if (st.armed && (d_lap >= {16'd0, cfg.min_lap_ms})) begin
              res.lap_recorded      = 1'b1;
              res.lap_ms            = d_lap;
              st_next.laps_done     = laps_inc;
              st_next.last_lap_time = now_ms;
              st_next.armed         = 1'b0;
              if ((cfg.lap_goal != 8'd0) && (laps_inc >= {8'd0, cfg.lap_goal})) begin
                res.finish_cause = CAUSE_GOAL;
                res.total_ms     = d_start;
                final_count      = laps_inc;
                st_next          = clear_track(st_next);
              end
            end
          end
          st_next.prev_beam = beam_broken;
        end
        // a race started on this word has zero elapsed time
        d_start_eff = started ? 32'd0 : d_start;
        if (st_next.locked) begin
          if (!st_next.running) begin
            if (d_lock >= cfg.lock_timeout_ms) begin
              res.finish_cause = CAUSE_LOCK_EXPIRED;
              final_count      = st_next.laps_done;
              st_next          = clear_track(st_next);
            end
          end else if (d_start_eff >= cfg.race_timeout_ms) begin
            res.finish_cause = CAUSE_RACE_TIMEOUT;
            res.total_ms     = d_start_eff;
            final_count      = st_next.laps_done;
            st_next          = clear_track(st_next);
          end
        end
      end
      CMD_LOCK: begin
        d_start_eff = d_start;
        if (st.locked) begin
          res.cmd_ok = 1'b0;
        end else begin
          st_next           = clear_track(st);
          st_next.locked    = 1'b1;
          st_next.ready     = !beam_broken;
          st_next.lock_time = now_ms;
        end
      end
      CMD_RESET: begin
        d_start_eff = d_start;
        if (!st.locked) begin
          res.cmd_ok = 1'b0;
        end else begin
          res.finish_cause = CAUSE_RESET;
          res.total_ms     = st.running ? d_start : 32'd0;
          final_count      = st.laps_done;
          st_next          = clear_track(st);
        end
      end
      default: begin
        d_start_eff = d_start;
        res.cmd_ok  = 1'b0;
      end
    endcase

    res.lap_count    = (res.finish_cause != CAUSE_NONE) ? final_count : st_next.laps_done;
    res.track_locked = st_next.locked;
    res.race_running = st_next.running;
    res.start_ready  = st_next.ready;
    res.lap_armed    = st_next.armed;
    res.timer_ms     = (st_next.locked && st_next.running) ? d_start_eff : 32'd0;
  end

endmodule

/* design/beam_gate_lap_timer.sv */
// ----------------------------------------------------------------------------
// beam_gate_lap_timer
// Light-beam lap timer: lock, start, laps, goal and timeouts, one result word
// per input word.
// ----------------------------------------------------------------------------
// Path: a word on s_tdata goes through the input register, then the result
// register, whose valid flag drives m_tvalid and whose result is m_tdata.
// Throughput: 1 word per cycle while m_tready allows; the timer state updates
// as a word moves from the input register into the result register.
// Reset (rst, sync): both stages empty, all flags, times and laps cleared,
// beam taken as clear, registers back to their defaults.
module beam_gate_lap_timer
  import bglt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // beam_broken, now_ms[31:0], pad
  input  logic [1:0]            s_tuser,   // cmd
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata    // cmd_ok, lap_recorded, lap_ms,
                                           // lap_count, finish_cause, total_ms,
                                           // track_locked, race_running,
                                           // start_ready, lap_armed,
                                           // timer_ms, pad
);

  bglt_cfg_t    cfg;
  bglt_state_t  st;
  bglt_state_t  st_next;
  bglt_result_t res;
  bglt_result_t out_res;

  logic        in_v;
  logic [1:0]  in_cmd;
  logic        in_beam;
  logic [31:0] in_now;
  logic        out_v;
  logic        adv;

  assign adv      = !out_v || m_tready;
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lap_goal        <= LAP_GOAL_RST;
      cfg.min_lap_ms      <= MIN_LAP_MS_RST;
      cfg.lock_timeout_ms <= LOCK_TIMEOUT_MS_RST;
      cfg.race_timeout_ms <= RACE_TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAP_GOAL:        cfg.lap_goal        <= cfg_data[7:0];
        REG_MIN_LAP_MS:      cfg.min_lap_ms      <= cfg_data[15:0];
        REG_LOCK_TIMEOUT_MS: cfg.lock_timeout_ms <= cfg_data;
        REG_RACE_TIMEOUT_MS: cfg.race_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_beam <= s_tdata[0];
      in_now  <= s_tdata[32:1];
    end
  end

  bglt_step u_step (
    .cfg         (cfg),
    .st          (st),
    .cmd         (in_cmd),
    .beam_broken (in_beam),
    .now_ms      (in_now),
    .st_next     (st_next),
    .res         (res)
  );

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= in_v;
      if (in_v) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {7'd0,
                     out_res.timer_ms,
                     out_res.lap_armed,
                     out_res.start_ready,
                     out_res.race_running,
                     out_res.track_locked,
                     out_res.total_ms,
                     out_res.finish_cause,
                     out_res.lap_count,
                     out_res.lap_ms,
                     out_res.lap_recorded,
                     out_res.cmd_ok};

endmodule
